// ===== sv/rsw_pkg.sv =====
package rsw_pkg;

  localparam int PARTICLES   = 1024;
  localparam int WEIGHT_BITS = 16;
  localparam int POSE_BITS   = 32;

  localparam int SLOT_BITS  = $clog2(PARTICLES);
  localparam int COUNT_BITS = SLOT_BITS + 1;
  localparam int STEP_BITS  = COUNT_BITS + 2;
  localparam int FRAC_BITS  = 17;
  localparam int BETA_BITS  = WEIGHT_BITS + 2;
  localparam int PROD_BITS  = FRAC_BITS + WEIGHT_BITS;
  localparam int INC_LSB    = FRAC_BITS - 2;
  localparam int POSE_WORDS = 3;

  localparam logic [FRAC_BITS-1:0]  FRAC_ONE  = FRAC_BITS'(65536);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(PARTICLES);

  typedef struct packed {
    logic                 load_en;
    logic [SLOT_BITS-1:0] load_slot;
    logic                 fetch_en;
    logic                 deliver;
    logic [SLOT_BITS-1:0] pick_slot;
  } rsw_ctrl_t;

endpackage

// ===== sv/rsw_wheel.sv =====
module rsw_wheel (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [rsw_pkg::COUNT_BITS-1:0]      count,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_mode,
  input  logic [rsw_pkg::SLOT_BITS-1:0]       in_slot,
  input  logic [rsw_pkg::WEIGHT_BITS-1:0]     in_weight,
  input  logic [rsw_pkg::FRAC_BITS-1:0]       in_frac,
  input  logic                                in_restart,
  input  logic [rsw_pkg::SLOT_BITS-1:0]       in_start,
  input  logic                                out_free,
  output rsw_pkg::rsw_ctrl_t                  ctrl
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_ADD     = 3'd1;
  localparam logic [2:0] ST_WALK    = 3'd2;
  localparam logic [2:0] ST_FETCH   = 3'd3;
  localparam logic [2:0] ST_DELIVER = 3'd4;

  logic [2:0]                          state;
  logic [2:0]                          state_next;
  logic [rsw_pkg::WEIGHT_BITS-1:0]     weight_mem [rsw_pkg::PARTICLES];
  logic [rsw_pkg::WEIGHT_BITS-1:0]     rd_data;
  logic [rsw_pkg::SLOT_BITS-1:0]       rd_addr;
  logic [rsw_pkg::WEIGHT_BITS-1:0]     max_weight;
  logic [rsw_pkg::BETA_BITS-1:0]       beta;
  logic [rsw_pkg::SLOT_BITS-1:0]       wheel_pos;
  logic [rsw_pkg::STEP_BITS-1:0]       steps;
  logic [rsw_pkg::PROD_BITS-1:0]       prod;

  logic                                accept;
  logic                                load;
  logic                                draw;
  logic [rsw_pkg::FRAC_BITS-1:0]       frac_c;
  logic [rsw_pkg::SLOT_BITS-1:0]       pos_sel;
  logic [rsw_pkg::SLOT_BITS-1:0]       pos_start;
  logic [rsw_pkg::BETA_BITS:0]         sum;
  logic [rsw_pkg::BETA_BITS-1:0]       beta_sat;
  logic [rsw_pkg::BETA_BITS-1:0]       w_ext;
  logic                                gt;
  logic                                more;
  logic [rsw_pkg::STEP_BITS-1:0]       limit;
  logic [rsw_pkg::COUNT_BITS-1:0]      pos_inc;
  logic [rsw_pkg::SLOT_BITS-1:0]       pos_wrap;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign load     = accept && !in_mode &&
                    ({1'b0, in_slot} < rsw_pkg::COUNT_MAX);
  assign draw     = accept && in_mode;

  assign frac_c = (in_frac > rsw_pkg::FRAC_ONE) ? rsw_pkg::FRAC_ONE : in_frac;

  always_comb begin
    if (in_restart) begin
      pos_sel = ({1'b0, in_start} < count) ? in_start : '0;
    end else begin
      pos_sel = wheel_pos;
    end
    pos_start = ({1'b0, pos_sel} >= count) ? '0 : pos_sel;
  end

  assign sum      = {1'b0, beta} + {1'b0, prod[rsw_pkg::PROD_BITS-1:rsw_pkg::INC_LSB]};
  assign beta_sat = sum[rsw_pkg::BETA_BITS] ? '1 : sum[rsw_pkg::BETA_BITS-1:0];

  assign w_ext    = {2'b00, rd_data};
  assign gt       = beta > w_ext;
  assign limit    = {count, 2'b00};
  assign more     = gt && (steps < limit);
  assign pos_inc  = {1'b0, wheel_pos} + 1'b1;
  assign pos_wrap = (pos_inc >= count) ? '0 : pos_inc[rsw_pkg::SLOT_BITS-1:0];

  assign rd_addr = (state == ST_WALK && more) ? pos_wrap : wheel_pos;

  always_ff @(posedge clk) begin
    if (load) begin
      weight_mem[in_slot] <= in_weight;
    end
    rd_data <= weight_mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (draw) state_next = ST_ADD;
      ST_ADD:     state_next = ST_WALK;
      ST_WALK:    if (!more) state_next = ST_FETCH;
      ST_FETCH:   state_next = ST_DELIVER;
      ST_DELIVER: if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      max_weight <= '0;
      beta       <= '0;
      wheel_pos  <= '0;
    end else begin
      state <= state_next;
      if (load && (in_slot == '0 || in_weight > max_weight)) begin
        max_weight <= in_weight;
      end
      if (draw) begin
        wheel_pos <= pos_start;
        if (in_restart) begin
          beta <= '0;
        end
      end
      if (state == ST_ADD) begin
        beta <= beta_sat;
      end
      if (state == ST_WALK) begin
        if (more) begin
          beta      <= beta - w_ext;
          wheel_pos <= pos_wrap;
        end else if (gt) begin
          beta <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (draw) begin
      steps <= '0;
      prod  <= rsw_pkg::PROD_BITS'(frac_c) * rsw_pkg::PROD_BITS'(max_weight);
    end else if (state == ST_WALK && more) begin
      steps <= steps + 1'b1;
    end
  end

  always_comb begin
    ctrl.load_en   = load;
    ctrl.load_slot = in_slot;
    ctrl.fetch_en  = (state == ST_FETCH);
    ctrl.deliver   = (state == ST_DELIVER) && out_free;
    ctrl.pick_slot = wheel_pos;
  end

`ifndef SYNTHESIS
  a_draw_starts: assert property (@(posedge clk) disable iff (rst)
    draw |=> (state == ST_ADD))
    else $error("draw transfer did not start the accumulation");

  a_walk_ends_below: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && !more) |=> (beta <= $past(w_ext)))
    else $error("beta exceeds the weight at the stopping position");

  a_ctrl_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctrl.load_en, ctrl.fetch_en, ctrl.deliver}))
    else $error("load, fetch and deliver overlap");
`endif

endmodule

// ===== sv/rsw_pose_out.sv =====
module rsw_pose_out (
  input  logic                              clk,
  input  logic                              rst,
  input  rsw_pkg::rsw_ctrl_t                ctrl,
  input  logic [rsw_pkg::POSE_BITS-1:0]     in_x,
  input  logic [rsw_pkg::POSE_BITS-1:0]     in_y,
  input  logic [rsw_pkg::POSE_BITS-1:0]     in_heading,
  output logic                              out_free,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rsw_pkg::SLOT_BITS-1:0]     out_slot,
  output logic [rsw_pkg::POSE_BITS-1:0]     out_x,
  output logic [rsw_pkg::POSE_BITS-1:0]     out_y,
  output logic [rsw_pkg::POSE_BITS-1:0]     out_heading
);

  localparam int ROW_BITS = rsw_pkg::POSE_WORDS * rsw_pkg::POSE_BITS;

  logic [ROW_BITS-1:0] pose_mem [rsw_pkg::PARTICLES];
  logic [ROW_BITS-1:0] rd_data;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (ctrl.load_en) begin
      pose_mem[ctrl.load_slot] <= {in_heading, in_y, in_x};
    end
    if (ctrl.fetch_en) begin
      rd_data <= pose_mem[ctrl.pick_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.deliver) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.deliver) begin
      out_slot    <= ctrl.pick_slot;
      out_x       <= rd_data[rsw_pkg::POSE_BITS-1:0];
      out_y       <= rd_data[2*rsw_pkg::POSE_BITS-1:rsw_pkg::POSE_BITS];
      out_heading <= rd_data[3*rsw_pkg::POSE_BITS-1:2*rsw_pkg::POSE_BITS];
    end
  end

endmodule

// ===== sv/resampling_wheel.sv =====
// Particle resampling by the sampling wheel.
// The slave stream carries one item per transfer. tuser selects its kind: a
// load writes a weight and three pose words into a slot and updates the
// running maximum weight, a draw picks one particle and returns it on the
// master stream. Loads produce no output transfer.
// The slave side stays ready after a load. A draw goes from its transfer
// through an add step, a walk over the weights and a pose fetch to its result
// in the output register. Each step of the walk is one read of the weight
// memory, whose read latency paces it; it ends within 4 * particle_count steps.
// One item is handled at a time; the slave side is ready again once the draw
// has written its result to the output register.
// The output register holds a result until the receiver takes it; a stalled
// receiver therefore holds back the end of the next draw, not its start.
// Reset clears the maximum weight, the accumulator and the wheel position and
// sets particle_count to 1024. Particle memories are not cleared; a slot must
// be loaded before a draw can land on it. Write particle_count only while idle.
module resampling_wheel (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [10:0]  cfg_wr_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata, lowest bit up: slot, weight, pos_x, pos_y, heading, random_fraction,
  // restart, start_slot, two bits of padding.
  input  logic [151:0] s_tdata,
  // tuser: mode.
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata, lowest bit up: picked_slot, out_x, out_y, out_heading, six bits of
  // padding.
  output logic [111:0] m_tdata
);

  logic [rsw_pkg::COUNT_BITS-1:0]   count;
  logic [rsw_pkg::COUNT_BITS-1:0]   count_next;
  rsw_pkg::rsw_ctrl_t               ctrl;
  logic                             out_free;
  logic [rsw_pkg::SLOT_BITS-1:0]    out_slot;
  logic [rsw_pkg::POSE_BITS-1:0]    out_x;
  logic [rsw_pkg::POSE_BITS-1:0]    out_y;
  logic [rsw_pkg::POSE_BITS-1:0]    out_heading;

  always_comb begin
    priority if (cfg_wr_data == '0) begin
      count_next = rsw_pkg::COUNT_BITS'(1);
    end else if (cfg_wr_data > rsw_pkg::COUNT_MAX) begin
      count_next = rsw_pkg::COUNT_MAX;
    end else begin
      count_next = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= rsw_pkg::COUNT_MAX;
    end else if (cfg_wr_en) begin
      count <= count_next;
    end
  end

  rsw_wheel u_wheel (
    .clk        (clk),
    .rst        (rst),
    .count      (count),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_mode    (s_tuser),
    .in_slot    (s_tdata[9:0]),
    .in_weight  (s_tdata[25:10]),
    .in_frac    (s_tdata[138:122]),
    .in_restart (s_tdata[139]),
    .in_start   (s_tdata[149:140]),
    .out_free   (out_free),
    .ctrl       (ctrl)
  );

  rsw_pose_out u_pose_out (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .in_x        (s_tdata[57:26]),
    .in_y        (s_tdata[89:58]),
    .in_heading  (s_tdata[121:90]),
    .out_free    (out_free),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_slot    (out_slot),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_heading (out_heading)
  );

  assign m_tdata = {6'd0, out_heading, out_y, out_x, out_slot};

endmodule

// ===== tb/wheel_pick_checker.sv =====
package wheel_tb_pkg;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_DRAW = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic [1:0]  pad;
    logic [9:0]  start_slot;
    logic        restart;
    logic [16:0] frac;
    logic [31:0] heading;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
    logic [15:0] weight;
    logic [9:0]  slot;
  } wheel_item_t;

  typedef struct packed {
    logic [5:0]  pad;
    logic [31:0] out_heading;
    logic [31:0] out_y;
    logic [31:0] out_x;
    logic [9:0]  slot;
  } wheel_pick_t;

endpackage

module wheel_pick_checker
  import wheel_tb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [10:0]  cfg_wr_data,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [151:0] s_tdata,
  input  logic         s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [111:0] m_tdata,
  output int unsigned  failures,
  output int unsigned  pending
);

  logic [15:0] weight_mem [rsw_pkg::PARTICLES];
  logic [31:0] x_mem [rsw_pkg::PARTICLES];
  logic [31:0] y_mem [rsw_pkg::PARTICLES];
  logic [31:0] heading_mem [rsw_pkg::PARTICLES];
  logic [15:0] peak;
  logic [17:0] beta;
  logic [9:0]  wheel;
  int unsigned span;

  wheel_pick_t picks_due [$];
  wheel_item_t item;
  wheel_pick_t got;
  wheel_pick_t due;

  function automatic wheel_pick_t spin_wheel(input wheel_item_t it);
    logic [16:0] frac;
    logic [33:0] lift;
    logic [18:0] sum;
    int unsigned pos;
    int unsigned steps;
    wheel_pick_t pick;
    frac = (it.frac > rsw_pkg::FRAC_ONE) ? rsw_pkg::FRAC_ONE : it.frac;
    if (it.restart) begin
      beta = '0;
      wheel = (it.start_slot < span) ? it.start_slot : 10'd0;
    end
    if (wheel >= span) begin
      wheel = 10'd0;
    end
    lift = 34'(frac) * 34'(peak) * 34'd2;
    sum = 19'(beta) + 19'(lift[33:16]);
    beta = (sum > 19'h3FFFF) ? 18'h3FFFF : sum[17:0];
    pos = wheel;
    steps = 0;
    while (beta > weight_mem[pos] && steps < 4 * span) begin
      beta = beta - weight_mem[pos];
      pos = (pos + 1 >= span) ? 0 : pos + 1;
      steps++;
    end
    if (beta > weight_mem[pos]) begin
      beta = '0;
    end
    wheel = 10'(pos);
    pick = '0;
    pick.slot = 10'(pos);
    pick.out_x = x_mem[pos];
    pick.out_y = y_mem[pos];
    pick.out_heading = heading_mem[pos];
    return pick;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      peak = '0;
      beta = '0;
      wheel = '0;
      span = rsw_pkg::PARTICLES;
      failures = 0;
      picks_due.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_wr_data == 0) begin
          span = 1;
        end else if (cfg_wr_data > rsw_pkg::PARTICLES) begin
          span = rsw_pkg::PARTICLES;
        end else begin
          span = cfg_wr_data;
        end
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (picks_due.size() == 0) begin
          $error("result transfer with no draw outstanding: picked_slot %0d", got.slot);
          failures++;
        end else begin
          due = picks_due.pop_front();
          if (got.slot !== due.slot) begin
            $error("picked_slot: expected %0d, got %0d", due.slot, got.slot);
            failures++;
          end
          if (got.out_x !== due.out_x) begin
            $error("out_x: expected %h, got %h", due.out_x, got.out_x);
            failures++;
          end
          if (got.out_y !== due.out_y) begin
            $error("out_y: expected %h, got %h", due.out_y, got.out_y);
            failures++;
          end
          if (got.out_heading !== due.out_heading) begin
            $error("out_heading: expected %h, got %h", due.out_heading, got.out_heading);
            failures++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        item = s_tdata;
        if (s_tuser == MODE_DRAW) begin
          picks_due.push_back(spin_wheel(item));
        end else begin
          weight_mem[item.slot] = item.weight;
          x_mem[item.slot] = item.pos_x;
          y_mem[item.slot] = item.pos_y;
          heading_mem[item.slot] = item.heading;
          if (item.slot == 0 || item.weight > peak) begin
            peak = item.weight;
          end
        end
      end
    end
    pending <= picks_due.size();
  end

endmodule

// ===== tb/resampling_wheel_test.sv =====
module resampling_wheel_test;
  import wheel_tb_pkg::*;

  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 65;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_wr_en = 1'b0;
  logic [rsw_pkg::COUNT_BITS-1:0] cfg_wr_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [151:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [111:0] m_tdata;

  int unsigned failures;
  int unsigned pending;
  int unsigned span_now = rsw_pkg::PARTICLES;
  int tx_pct = 0;
  int rx_pct = 0;
  bit loaded [rsw_pkg::PARTICLES];

  resampling_wheel dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  wheel_pick_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .failures    (failures),
    .pending     (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Fields that the item's kind does not use carry random bits.
  function automatic wheel_item_t noise_item();
    logic [159:0] raw;
    wheel_item_t it;
    raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    it = raw[151:0];
    it.pad = '0;
    return it;
  endfunction

  function automatic wheel_item_t load_item(input logic [9:0] slot, input logic [15:0] w,
                                            input logic [31:0] x, input logic [31:0] y,
                                            input logic [31:0] h);
    wheel_item_t it;
    it = noise_item();
    it.slot = slot;
    it.weight = w;
    it.pos_x = x;
    it.pos_y = y;
    it.heading = h;
    return it;
  endfunction

  function automatic wheel_item_t draw_item(input logic [16:0] frac, input logic restart,
                                            input logic [9:0] start);
    wheel_item_t it;
    it = noise_item();
    it.frac = frac;
    it.restart = restart;
    it.start_slot = start;
    return it;
  endfunction

  function automatic logic [15:0] rand_weight();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(1, 255));
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [16:0] rand_fraction();
    case ($urandom_range(0, 7))
      0: return 17'd0;
      1: return rsw_pkg::FRAC_ONE;
      2: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic offer(input item_kind_e kind, input wheel_item_t it);
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= it;
    do @(posedge clk); while (!s_tready);
    if (kind == MODE_LOAD) begin
      loaded[it.slot] = 1'b1;
    end
    if (tx_pct != 0 && $urandom_range(0, 99) < tx_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_count(input logic [10:0] code);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= code;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (code == 0) begin
      span_now = 1;
    end else if (code > rsw_pkg::PARTICLES) begin
      span_now = rsw_pkg::PARTICLES;
    end else begin
      span_now = code;
    end
  endtask

  initial begin : receiver
    int taken;
    bit held;
    taken = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        taken++;
      end
      if (!held && taken >= 40) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
        m_tready <= 1'b1;
      end else if (rx_pct != 0 && $urandom_range(0, 99) < rx_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [10:0] code;
    logic [9:0] slot;
    logic [9:0] start;
    logic restart;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // A single particle: extremes of the pose words, a peak weight held by a slot
    // outside the wheel, a start slot beyond the count and a walk to the step limit.
    write_count(11'd0);
    offer(MODE_LOAD, load_item(10'd0, 16'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0));
    offer(MODE_DRAW, draw_item(17'd0, 1'b0, 10'd0));
    offer(MODE_LOAD, load_item(10'd5, 16'hFFFF, '1, '1, '1));
    offer(MODE_DRAW, draw_item(rsw_pkg::FRAC_ONE, 1'b1, 10'h3FF));
    offer(MODE_DRAW, draw_item(17'h1FFFF, 1'b0, 10'd0));
    offer(MODE_LOAD, load_item(10'd0, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, '1));
    offer(MODE_DRAW, draw_item(rsw_pkg::FRAC_ONE, 1'b1, 10'd0));
    offer(MODE_LOAD, load_item(10'd0, 16'd1, 32'd0, 32'd0, 32'd0));
    offer(MODE_DRAW, draw_item(rsw_pkg::FRAC_ONE, 1'b0, 10'd0));

    // Three particles of zero weight, then a walk that wraps several times.
    write_count(11'd3);
    offer(MODE_LOAD, load_item(10'd0, 16'd0, $urandom(), $urandom(), $urandom()));
    offer(MODE_LOAD, load_item(10'd1, 16'd0, $urandom(), $urandom(), $urandom()));
    offer(MODE_LOAD, load_item(10'd2, 16'd0, $urandom(), $urandom(), $urandom()));
    offer(MODE_LOAD, load_item(10'd7, 16'hFFFF, $urandom(), $urandom(), $urandom()));
    offer(MODE_DRAW, draw_item(rsw_pkg::FRAC_ONE, 1'b1, 10'd2));
    offer(MODE_DRAW, draw_item(17'd32768, 1'b0, 10'd0));
    offer(MODE_LOAD, load_item(10'd1, 16'd40000, $urandom(), $urandom(), $urandom()));
    offer(MODE_DRAW, draw_item(rsw_pkg::FRAC_ONE, 1'b1, 10'd0));
    offer(MODE_DRAW, draw_item(17'd0, 1'b1, 10'd1));

    // A full wheel, first from a count above the limit: a walk from the last
    // slot wraps to slot 0, and only loaded slots are ever visited.
    write_count(11'h7FF);
    offer(MODE_LOAD, load_item(10'd0, 16'hFFFF, $urandom(), $urandom(), $urandom()));
    offer(MODE_LOAD, load_item(10'd1023, 16'd0, $urandom(), $urandom(), $urandom()));
    offer(MODE_LOAD, load_item(10'd512, 16'd300, $urandom(), $urandom(), $urandom()));
    offer(MODE_DRAW, draw_item(17'd16384, 1'b1, 10'd1023));
    offer(MODE_DRAW, draw_item(17'd0, 1'b1, 10'd512));
    write_count(11'(rsw_pkg::PARTICLES));
    offer(MODE_DRAW, draw_item(17'd0, 1'b1, 10'd1023));
    offer(MODE_DRAW, draw_item(17'd16384, 1'b0, 10'd0));

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: code = 11'd2;
        1: code = 11'($urandom_range(3, 40));
        2: code = 11'($urandom_range(4, 120));
        3: code = 11'd1;
        4: code = 11'($urandom_range(41, 100));
        5: code = 11'($urandom_range(2, 16));
        default: code = 11'($urandom_range(2, 64));
      endcase
      write_count(code);
      if (ph == PHASES - 1) begin
        tx_pct = 0;
        rx_pct = 0;
      end else begin
        tx_pct = 20 * int'($urandom_range(0, 2));
        rx_pct = 20 * int'($urandom_range(0, 2));
      end
      for (int s = 0; s < span_now; s++) begin
        if (!loaded[s]) begin
          offer(MODE_LOAD, load_item(10'(s), rand_weight(), $urandom(), $urandom(), $urandom()));
        end
      end
      // The wheel may still stand beyond the new count.
      offer(MODE_DRAW, draw_item(rand_fraction(), 1'b0, 10'd0));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 35) begin
          if ($urandom_range(0, 9) < 7) begin
            slot = 10'($urandom_range(0, span_now - 1));
          end else begin
            slot = 10'($urandom());
          end
          offer(MODE_LOAD, load_item(slot, rand_weight(), $urandom(), $urandom(), $urandom()));
        end else begin
          restart = ($urandom_range(0, 3) == 0);
          if ($urandom_range(0, 4) == 0) begin
            start = 10'($urandom());
          end else begin
            start = 10'($urandom_range(0, span_now - 1));
          end
          offer(MODE_DRAW, draw_item(rand_fraction(), restart, start));
        end
      end
    end

    settle();
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/rsw_pkg.sv
sv/rsw_wheel.sv
sv/rsw_pose_out.sv
sv/resampling_wheel.sv
tb/wheel_pick_checker.sv
tb/resampling_wheel_test.sv
